// ===== rtl/core/stsc_pkg.sv =====
// Package with the shared types and constants of the sorted table search block.
`default_nettype none

package stsc_pkg;

	// Table geometry. The index and count widths are fixed by the stream fields.
	localparam int TableDepth = 1024;
	localparam int IdxW       = 10;
	localparam int CntW       = 11;
	localparam int KeyW       = 64;

	typedef enum logic [2:0] {
		CMD_LOAD   = 3'd0,
		CMD_SEARCH = 3'd1,
		CMD_BELOW  = 3'd2,
		CMD_ABOVE  = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH,
		S_SRCH_CMP,
		S_PIVOT_RD,
		S_PIVOT_LD,
		S_SCAN,
		S_DRAIN
	} state_t;

	// Extra terminal state kept apart so the enum above stays compact.
	typedef enum logic {
		R_BUSY,
		R_DONE
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_table_search_and_submask_count.sv =====
// Top level of the sorted table search and submask count block.
//
//   Channel  Direction  Data (low bit first)                        Sideband
//   s_*      in         key[63:0] position[73:64] range_low[83:74]   tuser: cmd[2:0]
//                       range_high[93:84], zero fill to 96
//   m_*      out        found_index[9:0] found[10] match_count[21:11] none
//                       status[23:22]
//
// A load, clear or rejected command is settled in the dispatch state. A search
// makes one probe per step through the single table read port. A submask count
// reads one entry per cycle through the same port.
// Reset clears the state machine, the entry count and the output valid; the
// table contents are left as they are and are only read below the entry count.
// A stalled result is held in the output register; the next input transfer is
// taken meanwhile, and its result waits until the output register is free.
`default_nettype none

module sorted_table_search_and_submask_count
	import stsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // key, position, range_low, range_high, zero fill
	input  wire logic [2:0]  s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // found_index, found, match_count, status
);

	// State and command registers.
	state_t               state_q, state_d;
	res_t                 res_q;
	logic [2:0]           cmd_q;
	logic [KeyW-1:0]      key_q;
	logic [IdxW-1:0]      pos_q, lo_q, hi_q;
	logic [CntW-1:0]      entry_count_q;

	// Search bounds: fi is the first live index, la is one past the last.
	logic [CntW-1:0]      fi_q, la_q, mi;
	logic [IdxW-1:0]      mi_q;

	// Scan state.
	logic [IdxW-1:0]      k_q, last_q;
	logic [KeyW-1:0]      pivot_q;
	logic                 scan_vld_s1;
	logic                 below_q;

	// Result registers.
	logic [IdxW-1:0]      res_idx_q;
	logic                 res_found_q;
	logic [CntW-1:0]      res_cnt_q;
	status_t              res_st_q;
	logic                 m_tvalid_q;
	logic [23:0]          m_tdata_q;

	// Memory port.
	logic                 ram_we;
	logic [IdxW-1:0]      ram_raddr;
	logic [KeyW-1:0]      ram_rdata;

	// Decisions on the latched command.
	logic                 s_xfer, out_free;
	logic                 tbl_full, hi_out, pos_out, range_empty;
	logic                 key_gt, key_lt, sub_hit;

	assign s_xfer      = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign tbl_full    = entry_count_q == CntW'(TableDepth);
	assign range_empty = lo_q > hi_q;
	assign hi_out      = {1'b0, hi_q} >= entry_count_q;
	assign pos_out     = {1'b0, pos_q} >= entry_count_q;
	assign mi          = fi_q + ((la_q - CntW'(1) - fi_q) >> 1);

	// Shared compare unit on the read data: ordering for a search, submask for a scan.
	assign key_gt  = key_q > ram_rdata;
	assign key_lt  = key_q < ram_rdata;
	assign sub_hit = below_q ? ((ram_rdata & pivot_q) == ram_rdata)
	                         : ((pivot_q & ram_rdata) == pivot_q);

	stsc_ram #(
		.Width(KeyW),
		.Depth(TableDepth)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(entry_count_q[IdxW-1:0]),
		.wdata(key_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_xfer) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (cmd_q)
					CMD_SEARCH: begin
						state_d = (range_empty || hi_out) ? S_IDLE : S_SRCH;
					end
					CMD_BELOW, CMD_ABOVE: begin
						state_d = pos_out ? S_IDLE : S_PIVOT_RD;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SRCH: begin
				state_d = (fi_q < la_q) ? S_SRCH_CMP : S_IDLE;
			end
			S_SRCH_CMP: begin
				state_d = (key_gt || key_lt) ? S_SRCH : S_IDLE;
			end
			S_PIVOT_RD: begin
				state_d = S_PIVOT_LD;
			end
			S_PIVOT_LD: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (k_q == last_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: memory port and input ready. A new command is
	// taken only once the previous result has moved into the output register.
	always_comb begin
		ram_we    = 1'b0;
		ram_raddr = k_q;
		s_tready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = res_q == R_BUSY;
			end
			S_DISPATCH: begin
				ram_we = (cmd_q == CMD_LOAD) && !tbl_full;
			end
			S_SRCH: begin
				ram_raddr = mi[IdxW-1:0];
			end
			S_PIVOT_RD: begin
				ram_raddr = pos_q;
			end
			default: begin
				ram_raddr = k_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			res_q         <= R_BUSY;
			entry_count_q <= '0;
			scan_vld_s1   <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= state_q == S_SCAN;

			// Every command ends with exactly one result, flagged here.
			if ((state_q != S_IDLE) && (state_d == S_IDLE)) begin
				res_q <= R_DONE;
			end else if ((res_q == R_DONE) && out_free) begin
				res_q <= R_BUSY;
			end

			if ((res_q == R_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (state_q == S_DISPATCH) begin
				if ((cmd_q == CMD_LOAD) && !tbl_full) begin
					entry_count_q <= entry_count_q + CntW'(1);
				end else if (cmd_q == CMD_CLEAR) begin
					entry_count_q <= '0;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cmd_q <= s_tuser;
			key_q <= s_tdata[KeyW-1:0];
			pos_q <= s_tdata[KeyW+IdxW-1:KeyW];
			lo_q  <= s_tdata[KeyW+2*IdxW-1:KeyW+IdxW];
			hi_q  <= s_tdata[KeyW+3*IdxW-1:KeyW+2*IdxW];
		end

		if ((res_q == R_DONE) && out_free) begin
			m_tdata_q <= {res_st_q, res_cnt_q, res_found_q, res_idx_q};
		end

		if (scan_vld_s1 && sub_hit) begin
			res_cnt_q <= res_cnt_q + CntW'(1);
		end

		unique case (state_q)
			S_DISPATCH: begin
				res_idx_q   <= '0;
				res_found_q <= 1'b0;
				res_cnt_q   <= '0;
				res_st_q    <= STS_OK;
				fi_q        <= {1'b0, lo_q};
				la_q        <= {1'b0, hi_q} + CntW'(1);
				below_q     <= cmd_q == CMD_BELOW;
				unique case (cmd_q)
					CMD_LOAD: begin
						if (tbl_full) begin
							res_st_q <= STS_FULL;
						end
					end
					CMD_SEARCH: begin
						if (!range_empty && hi_out) begin
							res_st_q <= STS_RANGE;
						end
					end
					CMD_BELOW, CMD_ABOVE: begin
						if (pos_out) begin
							res_st_q <= STS_RANGE;
						end
					end
					default: begin
					end
				endcase
			end
			S_SRCH: begin
				mi_q <= mi[IdxW-1:0];
			end
			S_SRCH_CMP: begin
				if (key_gt) begin
					fi_q <= {1'b0, mi_q} + CntW'(1);
				end else if (key_lt) begin
					la_q <= {1'b0, mi_q};
				end else begin
					res_idx_q   <= mi_q;
					res_found_q <= 1'b1;
				end
			end
			S_PIVOT_LD: begin
				pivot_q <= ram_rdata;
				if (below_q) begin
					k_q    <= '0;
					last_q <= pos_q;
				end else begin
					k_q    <= pos_q;
					last_q <= entry_count_q[IdxW-1:0] - IdxW'(1);
				end
			end
			S_SCAN: begin
				k_q <= k_q + IdxW'(1);
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The entry count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CntW'(TableDepth))
		else $error("entry count beyond table depth");

	// A compare result from the scan pipeline only exists right after a scan read.
	a_scan_stage: assert property (@(posedge clk) disable iff (!arst_n)
		scan_vld_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("scan compare outside scan");

	// A hit is only ever reported with an ok status and no count.
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[IdxW]) |-> (m_tdata[23:22] == STS_OK && m_tdata[21:11] == '0))
		else $error("hit with bad status or count");

	// A new command is never taken while an earlier one is being worked on.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == S_IDLE && res_q == R_BUSY))
		else $error("input ready while busy");

	// A result moves to the output exactly when the output register frees up.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(res_q == R_DONE && out_free) |=> m_tvalid)
		else $error("finished result not presented");

endmodule

`default_nettype wire

// ===== rtl/core/stsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stsc_ram #(
	parameter int Width = 64,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
